// ----- design/iva_pkg.sv -----
package iva_pkg;

  // default sizes of the vector space and the line table
  localparam int NUM_VECTORS_DEF  = 192;
  localparam int FIRST_VECTOR_DEF = 48;
  localparam int NUM_LINES_DEF    = 64;
  localparam int MAX_BLOCK_DEF    = 32;

  // lines that exist out of reset (legacy lines)
  localparam int ISA_LINES = 16;

  // width of a line number as carried in items and tables
  localparam int LINE_W = 6;

  // request kinds
  localparam logic [2:0] REQ_BLOCK = 3'd0;
  localparam logic [2:0] REQ_LINE  = 3'd1;
  localparam logic [2:0] REQ_FREE  = 3'd2;
  localparam logic [2:0] REQ_CFG   = 3'd3;
  localparam logic [2:0] REQ_XLATE = 3'd4;

  // result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_INVALID  = 3'd1;
  localparam logic [2:0] STAT_NO_LINE  = 3'd2;
  localparam logic [2:0] STAT_NO_SPACE = 3'd3;
  localparam logic [2:0] STAT_NO_INT   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SCAN,
    S_MARK,
    S_RESP
  } state_t;

  // commands to the vector map
  typedef struct packed {
    logic scan_start;
    logic scan_step;
    logic mark_step;
    logic mark_bind;
    logic vec_drop;
  } vm_cmd_t;

  // status back from the vector map
  typedef struct packed {
    logic hit;
    logic miss;
    logic mark_last;
  } vm_sts_t;

  // write enables of the line tables
  typedef struct packed {
    logic redir_we;
    logic attr_we;
    logic vec_we;
  } lm_cmd_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        vector_out;
    logic [LINE_W-1:0] line_out;
    logic              route_write;
    logic [LINE_W-1:0] route_line;
    logic [7:0]        route_vector;
    logic              route_polarity;
    logic              route_mode;
    logic              route_mask;
  } res_t;

endpackage

// ----- design/iva_vec_map.sv -----
module iva_vec_map #(
  parameter int NUM_VECTORS  = iva_pkg::NUM_VECTORS_DEF,
  parameter int FIRST_VECTOR = iva_pkg::FIRST_VECTOR_DEF,
  parameter int MAX_BLOCK    = iva_pkg::MAX_BLOCK_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  iva_pkg::vm_cmd_t                 cmd,
  input  logic [$clog2(MAX_BLOCK+1)-1:0]   count,
  input  logic [$clog2(NUM_VECTORS)-1:0]   rel_idx,
  input  logic [iva_pkg::LINE_W-1:0]       bind_line,
  output iva_pkg::vm_sts_t                 sts,
  output logic [$clog2(NUM_VECTORS)-1:0]   base,
  output logic                             bound_at,
  output logic [iva_pkg::LINE_W-1:0]       vline_rd
);
  import iva_pkg::*;

  localparam int VIW = $clog2(NUM_VECTORS);
  localparam int CW  = $clog2(MAX_BLOCK + 1);

  logic [NUM_VECTORS-1:0] free_r, free_nxt;
  logic [NUM_VECTORS-1:0] bound_r, bound_nxt;
  logic [VIW-1:0]         ptr_r, ptr_nxt;
  logic [VIW-1:0]         base_r, base_nxt;
  logic [CW-1:0]          run_r, run_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [LINE_W-1:0]      vline_mem [NUM_VECTORS];
  logic [LINE_W-1:0]      vline_rd_r;

  logic           bit_free;
  logic           aligned;
  logic           take;
  logic           at_end;
  logic [VIW-1:0] run_base;

  // run tracker: a run may only open on a vector aligned to the block size
  always_comb begin
    bit_free = free_r[ptr_r];
    aligned  = ((32'(FIRST_VECTOR) + 32'(ptr_r)) & (32'(cnt_r) - 32'd1)) == 32'd0;
    take     = bit_free && ((run_r != '0) || aligned);
    run_base = (run_r == '0) ? ptr_r : base_r;
    at_end   = ptr_r == VIW'(NUM_VECTORS - 1);
  end

  assign sts.hit       = cmd.scan_step && take && ((run_r + CW'(1)) == cnt_r);
  assign sts.miss      = cmd.scan_step && !sts.hit && at_end;
  assign sts.mark_last = cmd.mark_step && (run_r == CW'(1));
  assign base          = run_base;
  assign bound_at      = bound_r[rel_idx];
  assign vline_rd      = vline_rd_r;

  always_comb begin
    free_nxt  = free_r;
    bound_nxt = bound_r;
    ptr_nxt   = ptr_r;
    base_nxt  = base_r;
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    priority if (cmd.scan_start) begin
      ptr_nxt = '0;
      run_nxt = '0;
      cnt_nxt = count;
    end else if (cmd.scan_step) begin
      if (sts.hit) begin
        // rewind to the run start, run counter now counts vectors left to mark
        ptr_nxt = run_base;
        run_nxt = cnt_r;
      end else begin
        run_nxt  = take ? (run_r + CW'(1)) : '0;
        base_nxt = run_base;
        ptr_nxt  = ptr_r + VIW'(1);
      end
    end else if (cmd.mark_step) begin
      free_nxt[ptr_r] = 1'b0;
      if (cmd.mark_bind) begin
        bound_nxt[ptr_r] = 1'b1;
      end
      ptr_nxt = ptr_r + VIW'(1);
      run_nxt = run_r - CW'(1);
    end else if (cmd.vec_drop) begin
      free_nxt[rel_idx]  = 1'b1;
      bound_nxt[rel_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= '1;
      bound_r <= '0;
      ptr_r   <= '0;
      run_r   <= '0;
      cnt_r   <= '0;
    end else begin
      free_r  <= free_nxt;
      bound_r <= bound_nxt;
      ptr_r   <= ptr_nxt;
      run_r   <= run_nxt;
      cnt_r   <= cnt_nxt;
    end
    base_r <= base_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_step && cmd.mark_bind) begin
      vline_mem[ptr_r] <= bind_line;
    end
    vline_rd_r <= vline_mem[rel_idx];
  end

endmodule

// ----- design/iva_line_mem.sv -----
module iva_line_mem #(
  parameter int NUM_VECTORS  = iva_pkg::NUM_VECTORS_DEF,
  parameter int FIRST_VECTOR = iva_pkg::FIRST_VECTOR_DEF,
  parameter int NUM_LINES    = iva_pkg::NUM_LINES_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  iva_pkg::lm_cmd_t                            cmd,
  input  logic [$clog2(NUM_LINES)-1:0]                rd_addr,
  input  logic [$clog2(NUM_LINES)-1:0]                redir_addr,
  input  logic [iva_pkg::LINE_W-1:0]                  redir_data,
  input  logic [$clog2(NUM_LINES)-1:0]                attr_addr,
  input  logic                                        attr_pol,
  input  logic                                        attr_mode,
  input  logic [$clog2(NUM_LINES)-1:0]                vec_addr,
  input  logic [$clog2(FIRST_VECTOR+NUM_VECTORS)-1:0] vec_data,
  output logic [iva_pkg::LINE_W-1:0]                  redir_rd,
  output logic                                        present_rd,
  output logic                                        pol_rd,
  output logic                                        mode_rd,
  output logic [$clog2(FIRST_VECTOR+NUM_VECTORS)-1:0] lvec_rd
);
  import iva_pkg::*;

  localparam int LIW = $clog2(NUM_LINES);
  localparam int VNW = $clog2(FIRST_VECTOR + NUM_VECTORS);

  logic [LINE_W-1:0] redir_mem [NUM_LINES];
  logic [1:0]        attr_mem  [NUM_LINES];
  logic [VNW-1:0]    vec_mem   [NUM_LINES];

  // entries never written read back as their reset value
  logic [NUM_LINES-1:0] redir_vld_r;
  logic [NUM_LINES-1:0] attr_vld_r;
  logic [NUM_LINES-1:0] vec_vld_r;

  logic [LINE_W-1:0] redir_q;
  logic [1:0]        attr_q;
  logic [VNW-1:0]    vec_q;
  logic [LIW-1:0]    rd_addr_r;
  logic              redir_ok_r;
  logic              attr_ok_r;
  logic              vec_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      redir_vld_r <= '0;
      attr_vld_r  <= '0;
      vec_vld_r   <= '0;
      redir_ok_r  <= 1'b0;
      attr_ok_r   <= 1'b0;
      vec_ok_r    <= 1'b0;
    end else begin
      if (cmd.redir_we) begin
        redir_vld_r[redir_addr] <= 1'b1;
      end
      if (cmd.attr_we) begin
        attr_vld_r[attr_addr] <= 1'b1;
      end
      if (cmd.vec_we) begin
        vec_vld_r[vec_addr] <= 1'b1;
      end
      redir_ok_r <= redir_vld_r[rd_addr];
      attr_ok_r  <= attr_vld_r[rd_addr];
      vec_ok_r   <= vec_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.redir_we) begin
      redir_mem[redir_addr] <= redir_data;
    end
    if (cmd.attr_we) begin
      attr_mem[attr_addr] <= {attr_pol, attr_mode};
    end
    if (cmd.vec_we) begin
      vec_mem[vec_addr] <= vec_data;
    end
    redir_q   <= redir_mem[rd_addr];
    attr_q    <= attr_mem[rd_addr];
    vec_q     <= vec_mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  assign redir_rd   = redir_ok_r ? redir_q : LINE_W'(rd_addr_r);
  assign present_rd = attr_ok_r | ({1'b0, rd_addr_r} < (LIW + 1)'(ISA_LINES));
  assign pol_rd     = attr_ok_r & attr_q[1];
  assign mode_rd    = attr_ok_r & attr_q[0];
  assign lvec_rd    = vec_ok_r ? vec_q : '0;

endmodule

// ----- design/interrupt_vector_allocator_core.sv -----
// channel | dir | tdata (low bit up)                          | tuser
// in_     | in  | block_count, line_index, source_line,       | req_type
//         |     | vector_in, polarity_in, mode_in, zero pad   |
// out_    | out | vector_out, line_out, route_write,          | status
//         |     | route_line, route_vector, route_polarity,   |
//         |     | route_mode, route_mask                      |
//
// one item in flight: accept, table read, decode, then an optional scan
// the scan walks the free map one vector per cycle, then marks the run one per cycle
// block or line allocation: scans up to NUM_VECTORS vectors, then claims the vectors of
// the run it found; other requests, and a line that is already bound, skip the scan
// the result sits in an output register, so the next item is taken while it waits
// reset is synchronous, active low; the line tables need no clearing pass
module interrupt_vector_allocator_core #(
  parameter int NUM_VECTORS  = iva_pkg::NUM_VECTORS_DEF,
  parameter int FIRST_VECTOR = iva_pkg::FIRST_VECTOR_DEF,
  parameter int NUM_LINES    = iva_pkg::NUM_LINES_DEF,
  parameter int MAX_BLOCK    = iva_pkg::MAX_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // block_count[5:0], line_index[11:6], source_line[17:12], vector_in[25:18],
  // polarity_in[26], mode_in[27], zero[31:28]
  input  logic [31:0] in_tdata,
  // req_type[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // vector_out[7:0], line_out[13:8], route_write[14], route_line[20:15],
  // route_vector[28:21], route_polarity[29], route_mode[30], route_mask[31]
  output logic [31:0] out_tdata,
  // status[2:0]
  output logic [2:0]  out_tuser
);
  import iva_pkg::*;

  localparam int VIW = $clog2(NUM_VECTORS);
  localparam int VNW = $clog2(FIRST_VECTOR + NUM_VECTORS);
  localparam int LIW = $clog2(NUM_LINES);
  localparam int CW  = $clog2(MAX_BLOCK + 1);

  state_t state_r, state_nxt;

  logic [2:0]        type_r;
  logic [5:0]        count_r;
  logic [LINE_W-1:0] line_r;
  logic [LINE_W-1:0] src_r;
  logic [7:0]        vec_r;
  logic              pol_r;
  logic              mode_r;

  res_t res_r, res_nxt;
  res_t out_r;
  logic out_vld_r, out_vld_nxt;
  logic out_load;
  logic in_acc;

  vm_cmd_t           vm_cmd;
  vm_sts_t           vm_sts;
  logic [CW-1:0]     vm_count;
  logic [VIW-1:0]    vm_rel;
  logic [VIW-1:0]    vm_base;
  logic              vm_bound;
  logic [LINE_W-1:0] vm_vline;

  lm_cmd_t           lm_cmd;
  logic [LIW-1:0]    lm_vec_addr;
  logic [VNW-1:0]    lm_vec_data;
  logic [LINE_W-1:0] lm_redir;
  logic              lm_present;
  logic              lm_pol;
  logic              lm_mode;
  logic [VNW-1:0]    lm_lvec;

  logic           cnt_ok;
  logic           line_ok;
  logic           src_ok;
  logic           vec_ok;
  logic           vline_ok;
  logic           go_scan;
  logic [VNW-1:0] vnum;

  assign in_acc   = in_tvalid && in_tready;
  assign cnt_ok   = (count_r != 6'd0) && ((count_r & (count_r - 6'd1)) == 6'd0) &&
                    (32'(count_r) <= MAX_BLOCK);
  assign line_ok  = 32'(line_r) < NUM_LINES;
  assign src_ok   = 32'(src_r) < NUM_LINES;
  assign vec_ok   = (32'(vec_r) >= FIRST_VECTOR) &&
                    (32'(vec_r) < (FIRST_VECTOR + NUM_VECTORS));
  assign vline_ok = 32'(vm_vline) < NUM_LINES;
  assign go_scan  = ((type_r == REQ_BLOCK) && cnt_ok) ||
                    ((type_r == REQ_LINE) && line_ok && lm_present && (lm_lvec == '0));
  assign vnum     = VNW'(32'(FIRST_VECTOR) + 32'(vm_base));
  assign vm_count = (type_r == REQ_BLOCK) ? CW'(count_r) : CW'(1);
  assign vm_rel   = VIW'(32'(vec_r) - 32'(FIRST_VECTOR));

  iva_vec_map #(
    .NUM_VECTORS  (NUM_VECTORS),
    .FIRST_VECTOR (FIRST_VECTOR),
    .MAX_BLOCK    (MAX_BLOCK)
  ) u_vec_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (vm_cmd),
    .count     (vm_count),
    .rel_idx   (vm_rel),
    .bind_line (line_r),
    .sts       (vm_sts),
    .base      (vm_base),
    .bound_at  (vm_bound),
    .vline_rd  (vm_vline)
  );

  iva_line_mem #(
    .NUM_VECTORS  (NUM_VECTORS),
    .FIRST_VECTOR (FIRST_VECTOR),
    .NUM_LINES    (NUM_LINES)
  ) u_line_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (lm_cmd),
    .rd_addr    (LIW'(line_r)),
    .redir_addr (LIW'(src_r)),
    .redir_data (line_r),
    .attr_addr  (LIW'(line_r)),
    .attr_pol   (pol_r),
    .attr_mode  (mode_r),
    .vec_addr   (lm_vec_addr),
    .vec_data   (lm_vec_data),
    .redir_rd   (lm_redir),
    .present_rd (lm_present),
    .pol_rd     (lm_pol),
    .mode_rd    (lm_mode),
    .lvec_rd    (lm_lvec)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: state_nxt = go_scan ? S_SCAN : S_RESP;
      S_SCAN: begin
        if (vm_sts.hit) begin
          state_nxt = S_MARK;
        end else if (vm_sts.miss) begin
          state_nxt = S_RESP;
        end
      end
      S_MARK: begin
        if (vm_sts.mark_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_vld_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and result assembly
  always_comb begin
    in_tready   = 1'b0;
    vm_cmd      = '0;
    lm_cmd      = '0;
    lm_vec_addr = LIW'(line_r);
    lm_vec_data = '0;
    res_nxt     = res_r;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_READ: ;
      S_EVAL: begin
        res_nxt        = '0;
        res_nxt.status = STAT_INVALID;
        unique case (type_r)
          REQ_BLOCK: begin
            vm_cmd.scan_start = cnt_ok;
          end
          REQ_LINE: begin
            if (!line_ok || !lm_present) begin
              res_nxt.status = STAT_NO_LINE;
            end else if (lm_lvec != '0) begin
              res_nxt.status     = STAT_OK;
              res_nxt.vector_out = 8'(lm_lvec);
            end else begin
              res_nxt.route_polarity = lm_pol;
              res_nxt.route_mode     = lm_mode;
              vm_cmd.scan_start      = 1'b1;
            end
          end
          REQ_FREE: begin
            if (vec_ok) begin
              res_nxt.status  = STAT_OK;
              vm_cmd.vec_drop = 1'b1;
              if (vm_bound) begin
                res_nxt.route_write = 1'b1;
                res_nxt.route_line  = vm_vline;
                res_nxt.route_mask  = 1'b1;
                lm_cmd.vec_we       = vline_ok;
                lm_vec_addr         = LIW'(vm_vline);
              end
            end
          end
          REQ_CFG: begin
            if (line_ok && src_ok) begin
              res_nxt.status  = STAT_OK;
              lm_cmd.redir_we = 1'b1;
              lm_cmd.attr_we  = 1'b1;
            end
          end
          REQ_XLATE: begin
            if (line_ok) begin
              res_nxt.status   = STAT_OK;
              res_nxt.line_out = lm_redir;
            end else begin
              res_nxt.status = STAT_NO_INT;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        vm_cmd.scan_step = 1'b1;
        if (vm_sts.hit) begin
          res_nxt.status     = STAT_OK;
          res_nxt.vector_out = 8'(vnum);
          if (type_r == REQ_LINE) begin
            res_nxt.route_write  = 1'b1;
            res_nxt.route_line   = line_r;
            res_nxt.route_vector = 8'(vnum);
            lm_cmd.vec_we        = 1'b1;
            lm_vec_data          = vnum;
          end
        end else if (vm_sts.miss) begin
          res_nxt        = '0;
          res_nxt.status = STAT_NO_SPACE;
        end
      end
      S_MARK: begin
        vm_cmd.mark_step = 1'b1;
        vm_cmd.mark_bind = type_r == REQ_LINE;
      end
      S_RESP: out_load = !out_vld_r || out_tready;
      default: ;
    endcase
  end

  assign out_vld_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (in_acc) begin
      type_r  <= in_tuser;
      count_r <= in_tdata[5:0];
      line_r  <= in_tdata[11:6];
      src_r   <= in_tdata[17:12];
      vec_r   <= in_tdata[25:18];
      pol_r   <= in_tdata[26];
      mode_r  <= in_tdata[27];
    end
    res_r <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {out_r.route_mask, out_r.route_mode, out_r.route_polarity,
                       out_r.route_vector, out_r.route_line, out_r.route_write,
                       out_r.line_out, out_r.vector_out};

  // one item at a time: no second accept right after the first
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
    vm_sts.hit |-> !vm_sts.miss)
    else $error("scan reported hit and miss together");

  a_mark_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_MARK) |-> $past(state_r) == S_SCAN && $past(vm_sts.hit))
    else $error("mark phase entered without a scan hit");

  a_route_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP && res_r.route_write |-> res_r.status == STAT_OK)
    else $error("routing write on a failed request");

endmodule

// ----- test/iva_monitor.sv -----
`timescale 1ns / 1ps
module iva_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [2:0]  out_tuser,
  output int          mismatches,
  output int          outstanding,
  output int          compared
);
  import iva_pkg::*;

  localparam int NV = NUM_VECTORS_DEF;
  localparam int FV = FIRST_VECTOR_DEF;
  localparam int NL = NUM_LINES_DEF;
  localparam int MB = MAX_BLOCK_DEF;

  // shadow of the allocator tables
  bit                vec_free     [NV];
  bit                vec_bound    [NV];
  logic [LINE_W-1:0] vec_owner    [NV];
  logic [LINE_W-1:0] line_redir   [NL];
  bit                line_present [NL];
  bit                line_pol     [NL];
  bit                line_mode    [NL];
  logic [7:0]        line_vec     [NL];

  res_t owed_results [$];
  res_t want;

  function automatic void clear_tables();
    for (int i = 0; i < NV; i++) begin
      vec_free[i]  = 1'b1;
      vec_bound[i] = 1'b0;
    end
    for (int i = 0; i < NL; i++) begin
      line_redir[i]   = LINE_W'(i);
      line_present[i] = (i < ISA_LINES);
      line_pol[i]     = 1'b0;
      line_mode[i]    = 1'b0;
      line_vec[i]     = 8'd0;
    end
  endfunction

  // first free run of count slots whose vector number is aligned to count
  function automatic int find_free_run(int count);
    bit fits;
    for (int s = 0; s + count <= NV; s++) begin
      if (((FV + s) & (count - 1)) != 0) continue;
      fits = 1'b1;
      for (int k = 0; k < count; k++)
        if (!vec_free[s + k]) fits = 1'b0;
      if (fits) return s;
    end
    return -1;
  endfunction

  // applies one request to the shadow tables and returns the answer it owes
  function automatic res_t serve_request(logic [2:0] kind, logic [31:0] data);
    logic [5:0]        count;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] src;
    logic [7:0]        vec;
    logic              pol;
    logic              mode;
    int                slot;
    int                idx;
    res_t              r;
    count = data[5:0];
    line  = data[11:6];
    src   = data[17:12];
    vec   = data[25:18];
    pol   = data[26];
    mode  = data[27];
    r = '0;
    r.status = STAT_INVALID;
    case (kind)
      REQ_BLOCK: begin
        if (count == 0 || (count & (count - 6'd1)) != 0 || count > MB) begin
          r.status = STAT_INVALID;
        end else begin
          slot = find_free_run(int'(count));
          if (slot < 0) begin
            r.status = STAT_NO_SPACE;
          end else begin
            for (int k = 0; k < count; k++) vec_free[slot + k] = 1'b0;
            r.status     = STAT_OK;
            r.vector_out = 8'(FV + slot);
          end
        end
      end
      REQ_LINE: begin
        if (line >= NL || !line_present[line]) begin
          r.status = STAT_NO_LINE;
        end else if (line_vec[line] != 0) begin
          r.status     = STAT_OK;
          r.vector_out = line_vec[line];
        end else begin
          slot = find_free_run(1);
          if (slot < 0) begin
            r.status = STAT_NO_SPACE;
          end else begin
            vec_free[slot]  = 1'b0;
            vec_bound[slot] = 1'b1;
            vec_owner[slot] = line;
            line_vec[line]  = 8'(FV + slot);
            r.status         = STAT_OK;
            r.vector_out     = line_vec[line];
            r.route_write    = 1'b1;
            r.route_line     = line;
            r.route_vector   = line_vec[line];
            r.route_polarity = line_pol[line];
            r.route_mode     = line_mode[line];
          end
        end
      end
      REQ_FREE: begin
        if (vec < FV || vec >= FV + NV) begin
          r.status = STAT_INVALID;
        end else begin
          idx = int'(vec) - FV;
          // a bound vector also masks its line
          if (vec_bound[idx]) begin
            r.route_write = 1'b1;
            r.route_line  = vec_owner[idx];
            r.route_mask  = 1'b1;
            if (vec_owner[idx] < NL) line_vec[vec_owner[idx]] = 8'd0;
            vec_bound[idx] = 1'b0;
          end
          vec_free[idx] = 1'b1;
          r.status = STAT_OK;
        end
      end
      REQ_CFG: begin
        if (src >= NL || line >= NL) begin
          r.status = STAT_INVALID;
        end else begin
          line_redir[src]    = line;
          line_pol[line]     = pol;
          line_mode[line]    = mode;
          line_present[line] = 1'b1;
          r.status = STAT_OK;
        end
      end
      REQ_XLATE: begin
        if (line >= NL) begin
          r.status = STAT_NO_INT;
        end else begin
          r.status   = STAT_OK;
          r.line_out = line_redir[line];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tables();
      owed_results.delete();
      mismatches  = 0;
      compared    = 0;
      outstanding = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        compared++;
        if (owed_results.size() == 0) begin
          $error("result item with nothing expected: status %0d data %h", out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          compare_field("status", want.status, out_tuser);
          compare_field("vector_out", want.vector_out, out_tdata[7:0]);
          compare_field("line_out", want.line_out, out_tdata[13:8]);
          compare_field("route_write", want.route_write, out_tdata[14]);
          compare_field("route_line", want.route_line, out_tdata[20:15]);
          compare_field("route_vector", want.route_vector, out_tdata[28:21]);
          compare_field("route_polarity", want.route_polarity, out_tdata[29]);
          compare_field("route_mode", want.route_mode, out_tdata[30]);
          compare_field("route_mask", want.route_mask, out_tdata[31]);
        end
      end
      if (in_tvalid && in_tready) owed_results.push_back(serve_request(in_tuser, in_tdata));
      outstanding = owed_results.size();
    end
  end

endmodule

// ----- test/interrupt_vector_allocator_core_tb.sv -----
`timescale 1ns / 1ps
module interrupt_vector_allocator_core_tb;
  import iva_pkg::*;

  // request kinds the block does not know
  localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNUSED_MID   = 3'd6;
  localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 1200;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  int mismatches;
  int outstanding;
  int compared;

  bit tx_steady;
  bit rx_steady;
  bit hold_off;
  bit hold_done;
  int kind_count [8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  interrupt_vector_allocator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  iva_monitor i_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  function automatic logic [31:0] item_fields(logic [5:0] count, logic [5:0] line,
                                              logic [5:0] src, logic [7:0] vec,
                                              logic pol, logic mode);
    return {4'b0, mode, pol, vec, src, line, count};
  endfunction

  task automatic send_item(logic [2:0] kind, logic [31:0] data);
    if (!tx_steady)
      while ($urandom_range(99) < 38) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    kind_count[kind]++;
  endtask

  // fill phases claim vectors, drain phases mostly release them
  task automatic send_random_item(bit draining);
    logic [31:0] data;
    logic [2:0]  kind;
    int          pick;
    int          cut_block, cut_line, cut_free, cut_cfg, cut_xlate;
    data = {4'b0, 28'($urandom)};
    pick = $urandom_range(99);
    if (draining) begin
      cut_block = 10; cut_line = 20; cut_free = 90; cut_cfg = 95; cut_xlate = 98;
    end else begin
      cut_block = 30; cut_line = 55; cut_free = 80; cut_cfg = 90; cut_xlate = 97;
    end
    if (pick < cut_block) begin
      kind = REQ_BLOCK;
      case ($urandom_range(9))
        0:       data[5:0] = 6'($urandom);
        1:       data[5:0] = 6'(8 << $urandom_range(2));
        default: data[5:0] = 6'(1 << $urandom_range(2));
      endcase
    end else if (pick < cut_line) begin
      kind = REQ_LINE;
      if ($urandom_range(1) != 0) data[11:6] = 6'($urandom_range(ISA_LINES - 1));
    end else if (pick < cut_free) begin
      kind = REQ_FREE;
      if ($urandom_range(6) != 0)
        data[25:18] = 8'($urandom_range(FIRST_VECTOR_DEF + NUM_VECTORS_DEF - 1,
                                         FIRST_VECTOR_DEF));
    end else if (pick < cut_cfg) begin
      kind = REQ_CFG;
    end else if (pick < cut_xlate) begin
      kind = REQ_XLATE;
    end else begin
      kind = 3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
    end
    send_item(kind, data);
  endtask

  // result side: random stalls, a steady stretch and one long hold-off
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off && !hold_done) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end
      out_tready <= rx_steady || ($urandom_range(99) >= 38);
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bad counts, then the first aligned single and 32-wide runs
    send_item(REQ_BLOCK, item_fields(6'd0, 6'd0, 6'd0, 8'd0, 1'b0, 1'b0));
    send_item(REQ_BLOCK, item_fields(6'd3, 6'd0, 6'd0, 8'd0, 1'b0, 1'b0));
    send_item(REQ_BLOCK, item_fields(6'd63, 6'd63, 6'd63, 8'd255, 1'b1, 1'b1));
    send_item(REQ_BLOCK, item_fields(6'd1, 6'd0, 6'd0, 8'd0, 1'b0, 1'b0));
    send_item(REQ_BLOCK, item_fields(6'd32, 6'd0, 6'd0, 8'd0, 1'b0, 1'b0));
    // fresh bind, already bound, absent line
    send_item(REQ_LINE, item_fields(6'd0, 6'd0, 6'd0, 8'd0, 1'b0, 1'b0));
    send_item(REQ_LINE, item_fields(6'd0, 6'd0, 6'd0, 8'd0, 1'b0, 1'b0));
    send_item(REQ_LINE, item_fields(6'd0, 6'd20, 6'd0, 8'd0, 1'b0, 1'b0));
    // top line made present with low-active level attributes, then bound
    send_item(REQ_CFG, item_fields(6'd0, 6'd63, 6'd63, 8'd0, 1'b1, 1'b1));
    send_item(REQ_LINE, item_fields(6'd0, 6'd63, 6'd0, 8'd0, 1'b0, 1'b0));
    send_item(REQ_XLATE, item_fields(6'd0, 6'd63, 6'd0, 8'd0, 1'b0, 1'b0));
    send_item(REQ_XLATE, item_fields(6'd0, 6'd0, 6'd0, 8'd0, 1'b0, 1'b0));
    // vectors outside the managed range
    send_item(REQ_FREE, item_fields(6'd0, 6'd0, 6'd0, 8'd0, 1'b0, 1'b0));
    send_item(REQ_FREE, item_fields(6'd0, 6'd0, 6'd0, 8'd47, 1'b0, 1'b0));
    send_item(REQ_FREE, item_fields(6'd0, 6'd0, 6'd0, 8'd240, 1'b0, 1'b0));
    send_item(REQ_FREE, item_fields(6'd0, 6'd0, 6'd0, 8'd255, 1'b0, 1'b0));
    // bound vector, the same one again once free, and a plain block vector
    send_item(REQ_FREE, item_fields(6'd0, 6'd0, 6'd0, 8'd49, 1'b0, 1'b0));
    send_item(REQ_FREE, item_fields(6'd0, 6'd0, 6'd0, 8'd49, 1'b0, 1'b0));
    send_item(REQ_FREE, item_fields(6'd0, 6'd0, 6'd0, 8'd48, 1'b0, 1'b0));
    send_item(REQ_UNUSED_FIRST, item_fields(6'd1, 6'd1, 6'd1, 8'd48, 1'b0, 1'b0));
    send_item(REQ_UNUSED_MID, item_fields(6'd1, 6'd1, 6'd1, 8'd48, 1'b0, 1'b0));
    send_item(REQ_UNUSED_LAST, item_fields(6'd1, 6'd1, 6'd1, 8'd48, 1'b0, 1'b0));
    // wide runs until the space runs out
    repeat (5) send_item(REQ_BLOCK, item_fields(6'd32, 6'd0, 6'd0, 8'd0, 1'b0, 1'b0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      tx_steady = (n >= 450 && n < 650) || (n >= 300 && n < 312);
      rx_steady = (n >= 450 && n < 650);
      if (n == 300) hold_off = 1'b1;
      if (n == 750) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
      end
      send_random_item(((n / 150) % 2) == 1);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    wait (outstanding == 0);
    repeat (250) @(posedge clk);

    $display("sent %0d requests: %0d block, %0d line, %0d free, %0d configure, %0d translate,"
             , kind_count.sum(), kind_count[REQ_BLOCK], kind_count[REQ_LINE],
             kind_count[REQ_FREE], kind_count[REQ_CFG], kind_count[REQ_XLATE]);
    $display("  %0d unknown kinds; %0d results checked, %0d mismatches",
             kind_count[REQ_UNUSED_FIRST] + kind_count[REQ_UNUSED_MID] +
             kind_count[REQ_UNUSED_LAST], compared, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- interrupt_vector_allocator_core.f -----
design/iva_pkg.sv
design/iva_vec_map.sv
design/iva_line_mem.sv
design/interrupt_vector_allocator_core.sv
test/iva_monitor.sv
test/interrupt_vector_allocator_core_tb.sv
